// File: src/fpsel_pkg.sv
// Shared types and constants for the fitness proportional selector.
package fpsel_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned FIT_W      = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned POP_W      = 9;
  localparam int unsigned SUM_W      = 41;
  localparam int unsigned OUT_SUM_W  = 40;
  localparam int unsigned MUL_SPLIT  = 21;
  localparam int unsigned DIV_CNT_W  = 6;
  localparam logic [POP_W-1:0] POP_SIZE_RST = 9'd256;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_STATS  = 2'd1,
    OP_SELECT = 2'd2
  } op_e;

  typedef struct packed {
    logic ram_we;
    logic latch_frac;
    logic start_scan;
    logic scan_sel;
    logic start_div;
    logic mul_lo;
    logic mul_hi;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_done;
  } status_t;

endpackage

// File: src/fpsel_ram.sv
// Generic single write port RAM with registered read.
module fpsel_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/fpsel_ctrl.sv
// Controller state machine: sequences load, statistics and select operations.
module fpsel_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [fpsel_pkg::OP_W-1:0] operation_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  input  fpsel_pkg::status_t      status_i,
  output fpsel_pkg::cmd_t         cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_SCAN     = 8'b0000_0010,
    ST_DIV_INIT = 8'b0000_0100,
    ST_DIV      = 8'b0000_1000,
    ST_MUL_LO   = 8'b0001_0000,
    ST_MUL_HI   = 8'b0010_0000,
    ST_SEL      = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (fpsel_pkg::op_e'(operation_i))
            fpsel_pkg::OP_LOAD: begin
              cmd_o.ram_we = 1'b1;
            end
            fpsel_pkg::OP_STATS: begin
              cmd_o.start_scan = 1'b1;
              state_d          = ST_SCAN;
            end
            fpsel_pkg::OP_SELECT: begin
              cmd_o.latch_frac = 1'b1;
              state_d          = ST_MUL_LO;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd_o.start_div = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi     = 1'b1;
        cmd_o.start_scan = 1'b1;
        cmd_o.scan_sel   = 1'b1;
        state_d          = ST_SEL;
      end
      ST_SEL: begin
        if (status_i.scan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/fpsel_datapath.sv
// Datapath: fitness table, scan accumulators, limit multiplier and mean divider.
module fpsel_datapath #(
  parameter int unsigned POP_MAX = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fpsel_pkg::cmd_t                   cmd_i,
  output fpsel_pkg::status_t                status_o,
  input  logic                              cfg_we_i,
  input  logic [fpsel_pkg::POP_W-1:0]       cfg_wdata_i,
  input  logic [fpsel_pkg::IDX_W-1:0]       entry_index_i,
  input  logic [fpsel_pkg::FIT_W-1:0]       fitness_value_i,
  input  logic [fpsel_pkg::FRAC_W-1:0]      random_fraction_i,
  output logic [fpsel_pkg::IDX_W-1:0]       selected_index_o,
  output logic [fpsel_pkg::FIT_W-1:0]       min_fitness_o,
  output logic [fpsel_pkg::IDX_W-1:0]       min_index_o,
  output logic [fpsel_pkg::FIT_W-1:0]       max_fitness_o,
  output logic [fpsel_pkg::IDX_W-1:0]       max_index_o,
  output logic [fpsel_pkg::FIT_W-1:0]       avg_fitness_o,
  output logic [fpsel_pkg::OUT_SUM_W-1:0]   fitness_sum_o
);

  localparam int unsigned AW     = $clog2(POP_MAX);
  localparam int unsigned CAP    = (POP_MAX < 256) ? POP_MAX : 256;
  localparam int unsigned IDX_W  = fpsel_pkg::IDX_W;
  localparam int unsigned FIT_W  = fpsel_pkg::FIT_W;
  localparam int unsigned SUM_W  = fpsel_pkg::SUM_W;
  localparam int unsigned POP_W  = fpsel_pkg::POP_W;
  localparam int unsigned FRAC_W = fpsel_pkg::FRAC_W;
  localparam int unsigned SPLIT  = fpsel_pkg::MUL_SPLIT;
  localparam int unsigned LO_W   = FRAC_W + SPLIT;
  localparam int unsigned HI_W   = FRAC_W + SUM_W - SPLIT;
  localparam int unsigned PROD_W = FRAC_W + SUM_W;
  localparam logic [POP_W-1:0] CAP_N = POP_W'(CAP);

  // configuration
  logic [POP_W-1:0] pop_size_q;
  logic [POP_W-1:0] used_n;
  logic [IDX_W-1:0] last_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_size_q <= fpsel_pkg::POP_SIZE_RST;
    end else if (cfg_we_i) begin
      pop_size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    priority if (pop_size_q == '0) begin
      used_n = POP_W'(1);
    end else if (pop_size_q > CAP_N) begin
      used_n = CAP_N;
    end else begin
      used_n = pop_size_q;
    end
  end

  assign last_idx = IDX_W'(used_n - POP_W'(1));

  // fitness table
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;
  logic [FIT_W-1:0] ram_rdata;
  logic [IDX_W-1:0] issue_cnt_q;

  assign ram_we    = cmd_i.ram_we && (32'(entry_index_i) < POP_MAX);
  assign ram_waddr = AW'(entry_index_i);
  assign ram_raddr = AW'(issue_cnt_q);

  fpsel_ram #(
    .WIDTH(FIT_W),
    .DEPTH(POP_MAX)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(fitness_value_i),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // limit = (fraction * kept sum) >> 16, as two partial products
  logic [FRAC_W-1:0] frac_q;
  logic [LO_W-1:0]   prod_lo_q;
  logic [HI_W-1:0]   prod_hi;
  logic [PROD_W-1:0] prod_full;
  logic [SUM_W-1:0]  limit_q;
  logic [SUM_W-1:0]  kept_sum_q;

  assign prod_hi   = frac_q * kept_sum_q[SUM_W-1:SPLIT];
  assign prod_full = PROD_W'(prod_lo_q) + (PROD_W'(prod_hi) << SPLIT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_frac) begin
      frac_q <= random_fraction_i;
    end
    if (cmd_i.mul_lo) begin
      prod_lo_q <= frac_q * kept_sum_q[SPLIT-1:0];
    end
    if (cmd_i.mul_hi) begin
      limit_q <= prod_full[PROD_W-1:FRAC_W];
    end
  end

  // table scan
  logic             issue_q;
  logic             rd_valid_q;
  logic             active_q;
  logic             sel_mode_q;
  logic [IDX_W-1:0] data_idx_q;
  logic [SUM_W-1:0] acc_q;
  logic [SUM_W-1:0] acc_new;
  logic [FIT_W-1:0] min_q, max_q;
  logic [IDX_W-1:0] min_idx_q, max_idx_q, sel_idx_q;
  logic             take;
  logic             is_last;
  logic             scan_done;

  assign take      = rd_valid_q && active_q;
  assign acc_new   = acc_q + SUM_W'(ram_rdata);
  assign is_last   = (data_idx_q == last_idx);
  assign scan_done = take && (is_last || (sel_mode_q && (acc_new >= limit_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q     <= 1'b0;
      rd_valid_q  <= 1'b0;
      active_q    <= 1'b0;
      sel_mode_q  <= 1'b0;
      issue_cnt_q <= '0;
      kept_sum_q  <= '0;
    end else if (cmd_i.start_scan) begin
      issue_q     <= 1'b1;
      rd_valid_q  <= 1'b0;
      active_q    <= 1'b1;
      sel_mode_q  <= cmd_i.scan_sel;
      issue_cnt_q <= '0;
    end else begin
      rd_valid_q <= issue_q;
      if (issue_q) begin
        issue_cnt_q <= issue_cnt_q + IDX_W'(1);
        if (issue_cnt_q == last_idx) begin
          issue_q <= 1'b0;
        end
      end
      if (scan_done) begin
        issue_q  <= 1'b0;
        active_q <= 1'b0;
        if (!sel_mode_q) begin
          kept_sum_q <= acc_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_idx_q <= issue_cnt_q;
    if (cmd_i.start_scan) begin
      acc_q <= '0;
    end else if (take) begin
      acc_q     <= acc_new;
      sel_idx_q <= data_idx_q;
      if (data_idx_q == '0 || ram_rdata < min_q) begin
        min_q     <= ram_rdata;
        min_idx_q <= data_idx_q;
      end
      if (data_idx_q == '0 || ram_rdata > max_q) begin
        max_q     <= ram_rdata;
        max_idx_q <= data_idx_q;
      end
    end
  end

  // restoring divider: kept sum / used count, one quotient bit per cycle
  logic                            div_busy_q;
  logic [fpsel_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic [POP_W-1:0]                rem_q;
  logic [SUM_W-1:0]                quo_q;
  logic [POP_W:0]                  trial;
  logic                            trial_ge;
  logic                            div_done;

  assign trial    = {rem_q, quo_q[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, used_n});
  assign div_done = div_busy_q && (div_cnt_q == fpsel_pkg::DIV_CNT_W'(SUM_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (cmd_i.start_div) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q + fpsel_pkg::DIV_CNT_W'(1);
      if (div_done) begin
        div_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_div) begin
      rem_q <= '0;
      quo_q <= kept_sum_q;
    end else if (div_busy_q) begin
      rem_q <= trial_ge ? POP_W'(trial - {1'b0, used_n}) : POP_W'(trial);
      quo_q <= {quo_q[SUM_W-2:0], trial_ge};
    end
  end

  assign status_o.scan_done = scan_done;
  assign status_o.div_done  = div_done;

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (sel_mode_q) begin
        selected_index_o <= sel_idx_q;
        min_fitness_o    <= '0;
        min_index_o      <= '0;
        max_fitness_o    <= '0;
        max_index_o      <= '0;
        avg_fitness_o    <= '0;
        fitness_sum_o    <= '0;
      end else begin
        selected_index_o <= '0;
        min_fitness_o    <= min_q;
        min_index_o      <= min_idx_q;
        max_fitness_o    <= max_q;
        max_index_o      <= max_idx_q;
        avg_fitness_o    <= quo_q[FIT_W-1:0];
        fitness_sum_o    <= kept_sum_q[fpsel_pkg::OUT_SUM_W-1:0];
      end
    end
  end

endmodule

// File: src/fitness_proportional_selector_core.sv
// Load writes one table entry; statistics walk n entries and then divide;
// select walks up to n entries, where n is the number of entries in use
// (pop_size clamped to 1..256). One item at a time; the table walk reads one
// entry per cycle from the single read port; the mean uses a restoring divide.
// A finished result waits in the output register while the next item is taken.
// Reset: asynchronous, active low; kept sum clears to 0, pop_size to 256.
module fitness_proportional_selector_core #(
  parameter int unsigned POP_MAX = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fpsel_pkg::POP_W-1:0]       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [fpsel_pkg::OP_W-1:0]        operation_i,
  input  logic [fpsel_pkg::IDX_W-1:0]       entry_index_i,
  input  logic [fpsel_pkg::FIT_W-1:0]       fitness_value_i,
  input  logic [fpsel_pkg::FRAC_W-1:0]      random_fraction_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fpsel_pkg::IDX_W-1:0]       selected_index_o,
  output logic [fpsel_pkg::FIT_W-1:0]       min_fitness_o,
  output logic [fpsel_pkg::IDX_W-1:0]       min_index_o,
  output logic [fpsel_pkg::FIT_W-1:0]       max_fitness_o,
  output logic [fpsel_pkg::IDX_W-1:0]       max_index_o,
  output logic [fpsel_pkg::FIT_W-1:0]       avg_fitness_o,
  output logic [fpsel_pkg::OUT_SUM_W-1:0]   fitness_sum_o
);

  fpsel_pkg::cmd_t    cmd;
  fpsel_pkg::status_t status;

  fpsel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operation_i(operation_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fpsel_datapath #(
    .POP_MAX(POP_MAX)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .entry_index_i    (entry_index_i),
    .fitness_value_i  (fitness_value_i),
    .random_fraction_i(random_fraction_i),
    .selected_index_o (selected_index_o),
    .min_fitness_o    (min_fitness_o),
    .min_index_o      (min_index_o),
    .max_fitness_o    (max_fitness_o),
    .max_index_o      (max_index_o),
    .avg_fitness_o    (avg_fitness_o),
    .fitness_sum_o    (fitness_sum_o)
  );

endmodule
